// ----- sv/rijndael_block_cipher_defines.svh -----
// Assertion macros for the block's checker file.
`ifndef RIJNDAEL_BLOCK_CIPHER_DEFINES_SVH
`define RIJNDAEL_BLOCK_CIPHER_DEFINES_SVH

// Concurrent assertion, clocked on the rising edge, off while in reset.
`define RBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rbc: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `RBC_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ----- sv/rbc_pkg.sv -----
// Types, constants and GF(2^8) helpers for the Rijndael block cipher.
package rbc_pkg;

  localparam int BLK_WORDS = 8;
  localparam int CNT_W     = 4;
  localparam int DATA_W    = 64;
  localparam int PADDR_W   = 6;

  typedef enum logic [2:0] {
    REG_KEY_0_7     = 3'd0,
    REG_KEY_8_15    = 3'd1,
    REG_KEY_16_23   = 3'd2,
    REG_KEY_24_31   = 3'd3,
    REG_KEY_WORDS   = 3'd4,
    REG_BLOCK_WORDS = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_KEY0,
    ST_ADD,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic key_step;
    logic rnd_inc;
    logic add_key;
    logic round;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_done;
    logic last_round;
    logic out_free;
  } dp_status_t;

  // Byte 0 in the top bits.
  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] ISBOX_BITS = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = SBOX_BITS[{~w[8*i +: 8], 3'b000} +: 8];
    return r;
  endfunction

  function automatic logic [31:0] inv_sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = ISBOX_BITS[{~w[8*i +: 8], 3'b000} +: 8];
    return r;
  endfunction

  function automatic logic [31:0] fwd_mix(input logic [31:0] w);
    logic [7:0] b [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) b[i] = w[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = xt(b[i]) ^ xt(b[(i+1)%4]) ^ b[(i+1)%4] ^ b[(i+2)%4] ^ b[(i+3)%4];
    end
    return r;
  endfunction

  function automatic logic [31:0] inv_mix(input logic [31:0] w);
    logic [7:0] x1 [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      x1[i] = w[8*i +: 8];
      x2[i] = xt(x1[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
    end
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = (x8[i] ^ x4[i] ^ x2[i])
                  ^ (x8[(i+1)%4] ^ x2[(i+1)%4] ^ x1[(i+1)%4])
                  ^ (x8[(i+2)%4] ^ x4[(i+2)%4] ^ x1[(i+2)%4])
                  ^ (x8[(i+3)%4] ^ x1[(i+3)%4]);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_words(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    if (v < CNT_W'(4)) return CNT_W'(4);
    if (v > hi) return hi;
    return v;
  endfunction

  // Source column of a ShiftRows byte; result stays below nb.
  function automatic logic [CNT_W-1:0] shift_src(input logic [CNT_W-1:0] j,
                                                 input logic [CNT_W-1:0] nb,
                                                 input logic [CNT_W-1:0] c,
                                                 input logic dec);
    logic [CNT_W:0] s;
    s = dec ? ({1'b0, j} + {1'b0, nb} - {1'b0, c}) : ({1'b0, j} + {1'b0, c});
    if (s >= {1'b0, nb}) s = s - {1'b0, nb};
    return s[CNT_W-1:0];
  endfunction

endpackage

// ----- sv/rbc_if.sv -----
// Stream interfaces for block input beats and result beats.
interface rbc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_bytes_0_7;
  logic [63:0] block_bytes_8_15;
  logic [63:0] block_bytes_16_23;
  logic [63:0] block_bytes_24_31;
  modport source (output valid, func, block_bytes_0_7, block_bytes_8_15,
                  block_bytes_16_23, block_bytes_24_31, input ready);
  modport sink (input valid, func, block_bytes_0_7, block_bytes_8_15,
                block_bytes_16_23, block_bytes_24_31, output ready);
endinterface

interface rbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes_0_7;
  logic [63:0] out_bytes_8_15;
  logic [63:0] out_bytes_16_23;
  logic [63:0] out_bytes_24_31;
  modport source (output valid, out_bytes_0_7, out_bytes_8_15, out_bytes_16_23,
                  out_bytes_24_31, input ready);
  modport sink (input valid, out_bytes_0_7, out_bytes_8_15, out_bytes_16_23,
                out_bytes_24_31, output ready);
endinterface

// ----- sv/rbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rbc_regs.sv -----
// APB configuration registers: key bytes and the key and block lengths.
module rbc_regs import rbc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  output logic [BLK_WORDS-1:0][31:0]    key_o,
  output logic [CNT_W-1:0]              key_words_o,
  output logic [CNT_W-1:0]              block_words_o,
  output logic                          cfg_wr_o
);

  logic [DATA_W-1:0] key_q [4];
  logic [CNT_W-1:0]  key_words_q;
  logic [CNT_W-1:0]  block_words_q;
  logic              wr;
  cfg_reg_e          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = cfg_reg_e'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      key_words_q   <= CNT_W'(4);
      block_words_q <= CNT_W'(4);
    end else if (wr) begin
      unique case (idx)
        REG_KEY_0_7:     key_q[0] <= pwdata;
        REG_KEY_8_15:    key_q[1] <= pwdata;
        REG_KEY_16_23:   key_q[2] <= pwdata;
        REG_KEY_24_31:   key_q[3] <= pwdata;
        REG_KEY_WORDS:   key_words_q <= pwdata[CNT_W-1:0];
        REG_BLOCK_WORDS: block_words_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_0_7:     prdata = key_q[0];
      REG_KEY_8_15:    prdata = key_q[1];
      REG_KEY_16_23:   prdata = key_q[2];
      REG_KEY_24_31:   prdata = key_q[3];
      REG_KEY_WORDS:   prdata = DATA_W'(key_words_q);
      REG_BLOCK_WORDS: prdata = DATA_W'(block_words_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_wr_o      = wr && (idx <= REG_BLOCK_WORDS);
  assign key_o         = {key_q[3], key_q[2], key_q[1], key_q[0]};
  assign key_words_o   = key_words_q;
  assign block_words_o = block_words_q;

endmodule

// ----- sv/rbc_ctrl.sv -----
// Sequencer: key schedule build, initial key add, rounds, result handoff.
module rbc_ctrl import rbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cfg_wr_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        sched_q, sched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sched_d    = sched_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sched_q ? ST_KEY0 : ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd_o.key_step = 1'b1;
        if (status_i.key_done) begin
          sched_d = 1'b1;
          state_d = ST_KEY0;
        end
      end
      ST_KEY0: begin
        cmd_o.rnd_inc = 1'b1;
        state_d       = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_key = 1'b1;
        cmd_o.rnd_inc = 1'b1;
        state_d       = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (status_i.last_round) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rnd_inc = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
    if (cfg_wr_i) sched_d = 1'b0;
  end

endmodule

// ----- sv/rbc_dp.sv -----
// Datapath: key expansion into round-key RAMs, shared round unit, result register.
module rbc_dp import rbc_pkg::*; #(
  parameter int MAX_WORDS       = 8,
  parameter int ROUND_KEY_DEPTH = 120
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  output dp_status_t                 status_o,
  input  logic [BLK_WORDS-1:0][31:0] key_i,
  input  logic [CNT_W-1:0]           key_words_i,
  input  logic [CNT_W-1:0]           block_words_i,
  input  logic                       func_i,
  input  logic [BLK_WORDS-1:0][31:0] blk_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [BLK_WORDS-1:0][31:0] out_data_o
);

  localparam int WIDX   = $clog2(MAX_WORDS);
  localparam int ROWS   = MAX_WORDS + 8;
  localparam int RA     = $clog2(ROWS);
  localparam int NW_MAX = MAX_WORDS * (MAX_WORDS + 7);
  localparam int IW     = $clog2(NW_MAX + 1);
  localparam int RW     = 32 * MAX_WORDS;

  logic [CNT_W-1:0] nb, nk, nr;

  assign nb = clamp_words(block_words_i, CNT_W'(MAX_WORDS));
  assign nk = clamp_words(key_words_i, CNT_W'(MAX_WORDS));
  assign nr = CNT_W'(6) + ((nb > nk) ? nb : nk);

  // key expansion
  logic [IW-1:0]    kwi_q, ib_q;
  logic [CNT_W-1:0] kcol_q, col_q;
  logic [RA-1:0]    row_q;
  logic [7:0]       rc_q;
  logic [31:0]      win_q [MAX_WORDS];
  logic [31:0]      rowbuf_q [MAX_WORDS];
  logic [31:0]      old_w, prev_w, new_w;
  logic             row_full, row_edge;
  logic [31:0]      fwd_row [MAX_WORDS];
  logic [RW-1:0]    fwd_wdata, inv_wdata;
  logic             key_we;

  assign prev_w = win_q[0];
  assign old_w  = win_q[WIDX'(nk - CNT_W'(1))];

  always_comb begin
    if (kwi_q < IW'(nk)) begin
      new_w = key_i[kwi_q[2:0]];
    end else if (kcol_q == '0) begin
      new_w = old_w ^ sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'h0, rc_q};
    end else if (nk > CNT_W'(6) && kcol_q == CNT_W'(4)) begin
      new_w = old_w ^ sub_word(prev_w);
    end else begin
      new_w = old_w ^ prev_w;
    end
    if (32'(kwi_q) >= 32'(ROUND_KEY_DEPTH)) new_w = '0;
  end

  assign row_full = (col_q == nb - CNT_W'(1));
  assign row_edge = (row_q == '0) || (row_q == RA'(nr));
  assign key_we   = cmd_i.key_step && row_full;

  for (genvar k = 0; k < MAX_WORDS; k++) begin : g_krow
    assign fwd_row[k] = (col_q == CNT_W'(k)) ? new_w : rowbuf_q[k];
    assign fwd_wdata[32*k +: 32] = fwd_row[k];
    assign inv_wdata[32*k +: 32] =
        (32'(ib_q) + 32'(k) >= 32'(ROUND_KEY_DEPTH)) ? 32'h0 :
        row_edge ? fwd_row[k] : inv_mix(fwd_row[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kwi_q  <= '0;
      kcol_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      ib_q   <= '0;
      rc_q   <= 8'h01;
    end else if (cmd_i.capture) begin
      kwi_q  <= '0;
      kcol_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      ib_q   <= IW'(nr) * IW'(nb);
      rc_q   <= 8'h01;
    end else if (cmd_i.key_step) begin
      kwi_q  <= kwi_q + IW'(1);
      kcol_q <= (kcol_q == nk - CNT_W'(1)) ? '0 : kcol_q + CNT_W'(1);
      if (kwi_q >= IW'(nk) && kcol_q == '0) rc_q <= xt(rc_q);
      if (row_full) begin
        col_q <= '0;
        row_q <= row_q + RA'(1);
        ib_q  <= ib_q - IW'(nb);
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_step) begin
      win_q[0] <= new_w;
      for (int k = 1; k < MAX_WORDS; k++) win_q[k] <= win_q[k-1];
      rowbuf_q[WIDX'(col_q)] <= new_w;
    end
  end

  // round-key storage, one row per round
  logic [RA-1:0] rnd_q;
  logic [RW-1:0] fwd_rd, inv_rd;

  rbc_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (row_q),
    .wdata_i (fwd_wdata),
    .raddr_i (rnd_q),
    .rdata_o (fwd_rd)
  );

  rbc_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (RA'(nr) - row_q),
    .wdata_i (inv_wdata),
    .raddr_i (rnd_q),
    .rdata_o (inv_rd)
  );

  // cipher rounds
  logic             func_q;
  logic [31:0]      blk_q [MAX_WORDS];
  logic [31:0]      st_q [MAX_WORDS];
  logic [31:0]      rk [MAX_WORDS];
  logic [31:0]      t [MAX_WORDS];
  logic [CNT_W-1:0] c2, c3;
  logic             last;

  assign c2   = (nb < CNT_W'(8)) ? CNT_W'(2) : CNT_W'(3);
  assign c3   = (nb < CNT_W'(8)) ? CNT_W'(3) : CNT_W'(4);
  assign last = (rnd_q == RA'(nr) + RA'(1));

  for (genvar j = 0; j < MAX_WORDS; j++) begin : g_col
    logic [CNT_W-1:0] s1, s2, s3;
    logic [31:0]      sh, fs, is;
    assign rk[j] = func_q ? inv_rd[32*j +: 32] : fwd_rd[32*j +: 32];
    assign s1 = shift_src(CNT_W'(j), nb, CNT_W'(1), func_q);
    assign s2 = shift_src(CNT_W'(j), nb, c2, func_q);
    assign s3 = shift_src(CNT_W'(j), nb, c3, func_q);
    assign sh = {st_q[WIDX'(s3)][31:24], st_q[WIDX'(s2)][23:16],
                 st_q[WIDX'(s1)][15:8], st_q[j][7:0]};
    assign fs = sub_word(sh);
    assign is = inv_sub_word(sh);
    assign t[j] = (func_q ? (last ? is : inv_mix(is)) : (last ? fs : fwd_mix(fs))) ^ rk[j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (cmd_i.capture) begin
      rnd_q <= '0;
    end else if (cmd_i.rnd_inc) begin
      rnd_q <= rnd_q + RA'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      for (int k = 0; k < MAX_WORDS; k++) blk_q[k] <= blk_i[k];
    end
    if (cmd_i.add_key) begin
      for (int k = 0; k < MAX_WORDS; k++) st_q[k] <= blk_q[k] ^ rk[k];
    end else if (cmd_i.round) begin
      for (int k = 0; k < MAX_WORDS; k++) st_q[k] <= t[k];
    end
  end

  // result register
  logic        out_valid_q;
  logic [31:0] out_q [MAX_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int k = 0; k < MAX_WORDS; k++) out_q[k] <= (CNT_W'(k) < nb) ? st_q[k] : 32'h0;
    end
  end

  for (genvar k = 0; k < BLK_WORDS; k++) begin : g_out
    if (k < MAX_WORDS) begin : g_used
      assign out_data_o[k] = out_q[k];
    end else begin : g_zero
      assign out_data_o[k] = 32'h0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.key_done   = cmd_i.key_step && row_full && (row_q == RA'(nr));
  assign status_o.last_round = last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- sv/rijndael_block_cipher.sv -----
// Top level of the Rijndael block cipher (4 to 8 word blocks and keys, ECB).
//
// Channels: in_i takes one block beat (func 0 encrypts, 1 decrypts, bytes
// in the low bits first); out_o gives one result beat per block, with words
// at or beyond the block length zero. The APB port writes the key bytes and
// the key and block lengths, always with pready high; the user is to write
// them only while the block is idle; the block itself does not enforce it.
// After any register write the first block waits for the key schedule to be
// rebuilt, one round-key word per cycle. With the schedule in place a block
// passes from its accept to its result beat through row 0 key read, initial
// key add, Nr rounds of the shared round unit and handoff, and the next block
// is taken only after that handoff; Nr = 6 + max(Nb, Nk), so 10 to 14 rounds.
// in_i.ready is high only when the sequencer is idle. A finished result
// sits in the output register until taken; a stalled receiver holds the
// next block in its last state until the register frees.
// Reset clears the registers to a 4-word key of zeros and a 4-word block,
// and marks the schedule as not built.
module rijndael_block_cipher import rbc_pkg::*; #(
  parameter int MAX_WORDS       = 8,
  parameter int ROUND_KEY_DEPTH = 120
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rbc_in_if.sink             in_i,
  rbc_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [BLK_WORDS-1:0][31:0] key_words, blk_words, res_words;
  logic [CNT_W-1:0]           nk_raw, nb_raw;
  logic                       cfg_wr;
  ctrl_cmd_t                  cmd;
  dp_status_t                 status;

  rbc_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .key_o         (key_words),
    .key_words_o   (nk_raw),
    .block_words_o (nb_raw),
    .cfg_wr_o      (cfg_wr)
  );

  rbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cfg_wr_i   (cfg_wr),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign blk_words = {in_i.block_bytes_24_31, in_i.block_bytes_16_23,
                      in_i.block_bytes_8_15, in_i.block_bytes_0_7};

  rbc_dp #(
    .MAX_WORDS       (MAX_WORDS),
    .ROUND_KEY_DEPTH (ROUND_KEY_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .key_i         (key_words),
    .key_words_i   (nk_raw),
    .block_words_i (nb_raw),
    .func_i        (in_i.func),
    .blk_i         (blk_words),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_data_o    (res_words)
  );

  assign out_o.out_bytes_0_7   = {res_words[1], res_words[0]};
  assign out_o.out_bytes_8_15  = {res_words[3], res_words[2]};
  assign out_o.out_bytes_16_23 = {res_words[5], res_words[4]};
  assign out_o.out_bytes_24_31 = {res_words[7], res_words[6]};

endmodule

// ----- sv/rbc_checker.sv -----
// Port-level checks on the cipher's handshakes, bound to the top level.
`include "rijndael_block_cipher_defines.svh"

module rbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `RBC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `RBC_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_valid && in_ready, !$rose(out_valid))
  `RBC_ASSERT(a_result_while_busy, clk_i, rst_ni, $rose(out_valid) |-> !$past(in_ready))
  `RBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)

endmodule

bind rijndael_block_cipher rbc_checker u_rbc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready)
);
